/* rtl/lrx_pkg.sv */
// Shared types, constants and sizes for the grey line rasterizer.
`timescale 1ns / 1ps
package lrx_pkg;

  // Frame store geometry.
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths.
  localparam int COORD_W = 11;
  localparam int GREY_W  = 8;
  localparam int AREA_W  = 9;
  localparam int DATA_W  = 56;
  localparam int CMP_W   = 14;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration port.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [GREY_W-1:0] WHITE = '1;

  typedef enum logic {
    OP_DRAW = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    REG_AREA_WIDTH  = 2'd0,
    REG_AREA_HEIGHT = 2'd1,
    REG_COMBINE     = 2'd2
  } reg_idx_e;

  // A classified request, ready for the pixel walker.
  typedef struct packed {
    opcode_e                    opcode;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic                       x_move;
    logic                       x_neg;
    logic                       y_move;
    logic                       y_neg;
    logic                       major_x;
    logic        [COORD_W-1:0]  es;
    logic        [COORD_W-1:0]  el;
    logic        [GREY_W-1:0]   colour;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic [AREA_W-1:0] area_width;
    logic [AREA_W-1:0] area_height;
    logic              combine_mode;
  } cfg_t;

endpackage

/* rtl/lrx_front.sv */
// Front end: takes requests from the input stream and classifies them for the walker.
`timescale 1ns / 1ps
module lrx_front (
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: start_x[10:0], start_y[21:11], end_x[32:22], end_y[43:33],
  //        grey_level[51:44], zero padding[55:52]
  input  logic [lrx_pkg::DATA_W-1:0]    s_axis_tdata,
  // tuser: opcode[0]
  input  logic                          s_axis_tuser,
  input  logic                          clear_busy_i,
  input  lrx_pkg::queue_status_t        q_status_i,
  output logic                          push_o,
  output lrx_pkg::cmd_t                 push_cmd_o
);
  import lrx_pkg::*;

  logic signed [COORD_W-1:0] sx, sy, ex, ey;
  logic signed [COORD_W:0]   dx, dy;
  logic        [COORD_W:0]   adx_w, ady_w;
  logic        [COORD_W-1:0] adx, ady;
  logic                      major_x;

  // Unpack the request.
  assign sx = s_axis_tdata[COORD_W-1:0];
  assign sy = s_axis_tdata[2*COORD_W-1:COORD_W];
  assign ex = s_axis_tdata[3*COORD_W-1:2*COORD_W];
  assign ey = s_axis_tdata[4*COORD_W-1:3*COORD_W];

  // Deltas, their magnitudes, and the major axis.
  always_comb begin
    dx      = {ex[COORD_W-1], ex} - {sx[COORD_W-1], sx};
    dy      = {ey[COORD_W-1], ey} - {sy[COORD_W-1], sy};
    adx_w   = dx[COORD_W] ? unsigned'(-dx) : unsigned'(dx);
    ady_w   = dy[COORD_W] ? unsigned'(-dy) : unsigned'(dy);
    adx     = adx_w[COORD_W-1:0];
    ady     = ady_w[COORD_W-1:0];
    major_x = adx > ady;
  end

  // Build the queued command.
  always_comb begin
    push_cmd_o.opcode  = opcode_e'(s_axis_tuser);
    push_cmd_o.x       = sx;
    push_cmd_o.y       = sy;
    push_cmd_o.x_move  = (dx != '0);
    push_cmd_o.x_neg   = dx[COORD_W];
    push_cmd_o.y_move  = (dy != '0);
    push_cmd_o.y_neg   = dy[COORD_W];
    push_cmd_o.major_x = major_x;
    push_cmd_o.es      = major_x ? ady : adx;
    push_cmd_o.el      = major_x ? adx : ady;
    push_cmd_o.colour  = s_axis_tdata[4*COORD_W+GREY_W-1:4*COORD_W];
  end

  assign s_axis_tready = !q_status_i.full && !clear_busy_i;
  assign push_o        = s_axis_tvalid && s_axis_tready;

endmodule

/* rtl/lrx_cmd_queue.sv */
// Short command queue that decouples the front end from the pixel walker.
`timescale 1ns / 1ps
module lrx_cmd_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  lrx_pkg::cmd_t          push_cmd_i,
  input  logic                   pop_i,
  output lrx_pkg::cmd_t          head_o,
  output lrx_pkg::queue_status_t status_o
);
  import lrx_pkg::*;

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  // Pointer and fill bookkeeping.
  always_comb begin
    wptr_d  = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = pop_i ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_cmd_i;
    end
  end

  assign head_o         = entry_q[rptr_q];
  assign status_o.full  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule

/* rtl/lrx_back.sv */
// Back end: frame store, clearing pass, Bresenham pixel walker and read result stage.
`timescale 1ns / 1ps
module lrx_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lrx_pkg::cfg_t               cfg_i,
  input  lrx_pkg::cmd_t               head_i,
  input  lrx_pkg::queue_status_t      q_status_i,
  output logic                        pop_o,
  output logic                        clear_busy_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tdata: pixel_value[7:0]
  output logic [lrx_pkg::GREY_W-1:0]  m_axis_tdata
);
  import lrx_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_WALK  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Walker registers.
  cmd_t                      cmd_q, cmd_d;
  logic signed [COORD_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [COORD_W:0]   err_q, err_d;
  logic        [COORD_W-1:0] count_q, count_d;
  logic        [ADDR_W-1:0]  clr_q, clr_d;

  // Pixel pipeline stage and store ports.
  logic              p1_valid_q, p1_vis_q, p1_read_q;
  logic [ADDR_W-1:0] p1_addr_q;
  logic [GREY_W-1:0] p1_colour_q;
  logic [GREY_W-1:0] store_q [STORE_DEPTH];
  logic [GREY_W-1:0] rdata_q, byp_data_q, old_pix;
  logic              byp_q;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] pix_addr, wr_addr;
  logic [GREY_W-1:0] wr_data;

  // Result register.
  logic              out_valid_q;
  logic [GREY_W-1:0] out_data_q;

  logic                      head_ok, issue, vis;
  logic signed [COORD_W+1:0] err_sub;
  logic signed [COORD_W-1:0] step_x, step_y;
  logic                      diag;
  logic        [CMP_W-1:0]   xu, yu;

  // A pixel lies on the store when it is inside both the area and the store bounds.
  always_comb begin
    xu  = CMP_W'(unsigned'(x_q[COORD_W-2:0]));
    yu  = CMP_W'(unsigned'(y_q[COORD_W-2:0]));
    vis = !x_q[COORD_W-1] && !y_q[COORD_W-1] &&
          (xu < CMP_W'(cfg_i.area_width))  && (xu < CMP_W'(MAX_WIDTH)) &&
          (yu < CMP_W'(cfg_i.area_height)) && (yu < CMP_W'(MAX_HEIGHT));
    pix_addr = ADDR_W'(ADDR_W'(yu) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(xu);
  end

  // A read request waits until no other read result is pending.
  assign head_ok = !q_status_i.empty &&
                   (head_i.opcode == OP_DRAW ||
                    (!out_valid_q && !(p1_valid_q && p1_read_q)));
  assign pop_o        = (state_q == ST_IDLE) && head_ok;
  assign issue        = (state_q == ST_WALK);
  assign clear_busy_o = (state_q == ST_CLEAR);

  // Bresenham step: error update and the direction of the next pixel.
  always_comb begin
    err_sub = {err_q[COORD_W], err_q} - signed'({2'b00, cmd_q.es});
    diag    = err_sub[COORD_W+1];
    step_x  = cmd_q.x_move ? (cmd_q.x_neg ? -COORD_W'(1) : COORD_W'(1)) : '0;
    step_y  = cmd_q.y_move ? (cmd_q.y_neg ? -COORD_W'(1) : COORD_W'(1)) : '0;
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    x_d     = x_q;
    y_d     = y_q;
    err_d   = err_q;
    count_d = count_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop_o) begin
          cmd_d   = head_i;
          x_d     = head_i.x;
          y_d     = head_i.y;
          err_d   = signed'({2'b00, head_i.el[COORD_W-1:1]});
          count_d = (head_i.opcode == OP_READ) ? '0 : head_i.el;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (count_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          count_d = count_q - 1'b1;
          if (diag) begin
            err_d = (COORD_W+1)'(err_sub + signed'({2'b00, cmd_q.el}));
            x_d   = x_q + step_x;
            y_d   = y_q + step_y;
          end else begin
            err_d = err_sub[COORD_W:0];
            if (cmd_q.major_x) begin
              x_d = x_q + step_x;
            end else begin
              y_d = y_q + step_y;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      count_q <= '0;
      err_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    x_q   <= x_d;
    y_q   <= y_d;
  end

  // Read-modify-write of the store; the bypass covers a write and read to the same byte.
  always_comb begin
    old_pix = byp_q ? byp_data_q : rdata_q;
    rd_en   = issue && vis;
    wr_en   = clear_busy_o || (p1_valid_q && p1_vis_q && !p1_read_q);
    wr_addr = clear_busy_o ? clr_q : p1_addr_q;
    if (clear_busy_o) begin
      wr_data = WHITE;
    end else if (cfg_i.combine_mode) begin
      wr_data = ~(p1_colour_q ^ old_pix);
    end else begin
      wr_data = p1_colour_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= store_q[pix_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p1_vis_q   <= 1'b0;
      p1_read_q  <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      p1_valid_q <= issue;
      p1_vis_q   <= vis;
      p1_read_q  <= (cmd_q.opcode == OP_READ);
      byp_q      <= wr_en && rd_en && (wr_addr == pix_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    p1_addr_q   <= pix_addr;
    p1_colour_q <= cmd_q.colour;
    byp_data_q  <= wr_data;
  end

  // Result register for read requests.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (p1_valid_q && p1_read_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_valid_q && p1_read_q) begin
      out_data_q <= p1_vis_q ? old_pix : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // The queue is never drained while the store is being cleared.
  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !clear_busy_o)
    else $error("request taken during clearing pass");

  // A read result never lands on an unconsumed one.
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_valid_q && p1_read_q) |-> !out_valid_q)
    else $error("read result would overwrite a pending result");

  // The walker covers exactly one pixel per cycle.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && count_q != '0) |=> (issue && count_q == $past(count_q) - 1'b1))
    else $error("walker step count skipped");

  // The Bresenham error term stays non-negative between steps.
  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> !err_q[COORD_W])
    else $error("error term out of range");

endmodule

/* rtl/line_rasterizer_xnor.sv */
// Top level of the grey line rasterizer: configuration registers and the front/queue/back split.
//
// Channel     | Dir | Handshake              | Contents
// s_axis      | in  | tvalid / tready        | draw or read request
// m_axis      | out | tvalid / tready        | pixel value of a read
// apb         | in  | psel, penable, pready  | area_width, area_height, combine_mode
//
// After reset the frame store is filled with white, one byte a cycle, over all 65536 bytes;
// no request is taken during that pass, configuration writes are.
// A draw is first loaded from the queue into the walker, which then makes one store read
// and write per pixel through the single store port pair.
// A read is loaded into the walker; the pixel stage passes its result to the result register.
// The queue holds 4 requests; until it is full the input side keeps running while the walker
// is busy and while a read result waits on the output.
`timescale 1ns / 1ps
module line_rasterizer_xnor (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: start_x[10:0], start_y[21:11], end_x[32:22], end_y[43:33],
  //        grey_level[51:44], zero padding[55:52]
  input  logic [lrx_pkg::DATA_W-1:0]        s_axis_tdata,
  // tuser: opcode[0]
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: pixel_value[7:0]
  output logic [lrx_pkg::GREY_W-1:0]        m_axis_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lrx_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [lrx_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [lrx_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import lrx_pkg::*;

  cfg_t          cfg_q;
  reg_idx_e      reg_idx;
  logic          cfg_wr;
  logic          push, pop, clear_busy;
  cmd_t          push_cmd, head;
  queue_status_t q_status;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.area_width   <= AREA_W'(256);
      cfg_q.area_height  <= AREA_W'(256);
      cfg_q.combine_mode <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_AREA_WIDTH:  cfg_q.area_width   <= pwdata[AREA_W-1:0];
        REG_AREA_HEIGHT: cfg_q.area_height  <= pwdata[AREA_W-1:0];
        REG_COMBINE:     cfg_q.combine_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_AREA_WIDTH:  prdata = CFG_DATA_W'(cfg_q.area_width);
      REG_AREA_HEIGHT: prdata = CFG_DATA_W'(cfg_q.area_height);
      REG_COMBINE:     prdata = CFG_DATA_W'(cfg_q.combine_mode);
      default:         prdata = '0;
    endcase
  end

  // Request classification.
  lrx_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .clear_busy_i  (clear_busy),
    .q_status_i    (q_status),
    .push_o        (push),
    .push_cmd_o    (push_cmd)
  );

  // Decoupling queue.
  lrx_cmd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (q_status)
  );

  // Pixel walker and frame store.
  lrx_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_i        (head),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .clear_busy_o  (clear_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
